@@ hdl/bal_pkg.sv @@
// Types and constants shared by the bounded array list engine.
// Request kinds, status codes, cell operations and the cell control beat.
// No dependencies.
package bal_pkg;

  typedef enum logic [3:0] {
    KIND_FRONT  = 4'd0,
    KIND_AT     = 4'd1,
    KIND_BACK   = 4'd2,
    KIND_REMOVE = 4'd3,
    KIND_SORT   = 4'd4,
    KIND_SEARCH = 4'd5,
    KIND_MAXMIN = 4'd6,
    KIND_CLEAR  = 4'd7,
    KIND_READ   = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_ROTATE  = 3'd2,
    CELL_COMPACT = 3'd3,
    CELL_SORT    = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic               phase;
    logic               keep;
    logic signed [31:0] key;
  } bal_ctrl_t;

endpackage

@@ hdl/bal_req_if.sv @@
// Request channel of the bounded array list engine.
// Carries valid, ready and one request beat. No dependencies.
interface bal_req_if;
  logic               valid;
  logic               ready;
  logic        [3:0]  kind;
  logic signed [31:0] key_value;
  logic        [3:0]  position;

  modport source(output valid, kind, key_value, position, input ready);
  modport sink(input valid, kind, key_value, position, output ready);
endinterface

@@ hdl/bal_rsp_if.sv @@
// Result channel of the bounded array list engine.
// Carries valid, ready and one result beat. No dependencies.
interface bal_rsp_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] key_out;
  logic signed [31:0] min_out;
  logic        [3:0]  position_out;
  logic        [3:0]  length;

  modport source(output valid, status, key_out, min_out, position_out, length, input ready);
  modport sink(input valid, status, key_out, min_out, position_out, length, output ready);
endinterface

@@ hdl/bal_cell.sv @@
// One slot of the key ring: holds a key and trades it with its neighbors.
// Depends on bal_pkg for the control beat and cell operations.
module bal_cell import bal_pkg::*; #(
  parameter int IW    = 3,
  parameter int CW    = 4,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  bal_ctrl_t          ctrl,
  input  logic [IW-1:0]      target,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] left_key,
  input  logic signed [31:0] right_key,
  input  logic signed [31:0] head_key,
  output logic signed [31:0] key
);

  localparam logic [IW-1:0] ME      = IW'(INDEX);
  localparam logic [CW:0]   ME_POS  = (CW+1)'(INDEX);
  localparam logic [CW:0]   NXT_POS = (CW+1)'(INDEX + 1);
  localparam logic          PAR     = 1'(INDEX % 2);
  localparam logic          HAS_L   = (INDEX >= 1);

  logic [CW:0] count_x;
  logic        pair_r;
  logic        pair_l;

  assign count_x = {1'b0, count};
  assign pair_r  = (PAR == ctrl.phase) && (NXT_POS < count_x);
  assign pair_l  = HAS_L && (PAR != ctrl.phase) && (ME_POS < count_x);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_INSERT: begin
        if (ME == target) begin
          key <= ctrl.key;
        end else if (ME > target) begin
          key <= left_key;
        end
      end
      CELL_ROTATE: begin
        key <= right_key;
      end
      CELL_COMPACT: begin
        if (ctrl.keep && (ME == target)) begin
          key <= head_key;
        end else begin
          key <= right_key;
        end
      end
      CELL_SORT: begin
        if (pair_r && (right_key < key)) begin
          key <= right_key;
        end else if (pair_l && (key < left_key)) begin
          key <= left_key;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/bounded_array_list_engine_top.sv @@
// Bounded array list engine: an ordered list of up to CAPACITY signed 32-bit keys held
// in a ring of cells. Each request beat yields one result beat. Inserts, clear, unused
// kinds and requests rejected on status finish after their first step; remove walks
// the list entries once; sort, search, maxmin and a valid read step through one full
// rotation (or CAPACITY odd-even exchange rounds) of the cell ring, one slot per
// cycle. One request is in flight at a time; the result sits in an output register.
// Depends on bal_pkg, bal_req_if, bal_rsp_if and bal_cell.
module bounded_array_list_engine_top import bal_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic      clk,
  input  logic      rst,
  bal_req_if.sink   req,
  bal_rsp_if.source rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 4) ? CW : 4) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state;
  logic        [3:0]  kind_r;
  logic signed [31:0] key_r;
  logic        [3:0]  pos_r;
  logic [CW-1:0]      count;
  logic [CW-1:0]      step;
  logic [CW-1:0]      kept;
  logic               found;
  status_t            res_status;
  logic signed [31:0] res_key;
  logic signed [31:0] res_min;
  logic        [3:0]  res_pos;

  logic               out_valid;
  logic        [2:0]  out_status;
  logic signed [31:0] out_key;
  logic signed [31:0] out_min;
  logic        [3:0]  out_pos;
  logic        [3:0]  out_len;

  logic signed [31:0] keys [CAPACITY];
  logic signed [31:0] head;
  bal_ctrl_t          ctrl;
  logic [IW-1:0]      target;
  logic               finish;

  logic [PW-1:0]      pos_x;
  logic [PW-1:0]      cnt_x;
  logic [PW-1:0]      step_x;
  logic [PW-1:0]      kept_x;
  logic [PW-1:0]      len_x;
  logic [CW-1:0]      kept_new;
  logic               full;
  logic               bad_ins;
  logic               bad_read;
  logic               in_list;
  logic               hit;
  logic               last_scan;
  logic               last_rem;
  logic               empty;

  assign head      = keys[0];
  assign pos_x     = PW'(pos_r);
  assign cnt_x     = PW'(count);
  assign step_x    = PW'(step);
  assign kept_x    = PW'(kept);
  assign empty     = (count == '0);
  assign full      = (count == CW'(CAPACITY));
  assign bad_ins   = (pos_x == '0) || (pos_x > cnt_x + PW'(1));
  assign bad_read  = (pos_x == '0) || (pos_x > cnt_x);
  assign in_list   = (step_x < cnt_x);
  assign hit       = in_list && (head == key_r);
  assign last_scan = (step == CW'(CAPACITY - 1));
  assign last_rem  = (step_x == cnt_x - PW'(1));
  assign kept_new  = kept + CW'(head != key_r);
  assign len_x     = PW'(count);

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.phase = step[0];
    ctrl.keep  = (head != key_r);
    ctrl.key   = key_r;
    target     = '0;
    finish     = 1'b1;
    if (state == S_RUN) begin
      case (kind_r)
        KIND_FRONT, KIND_AT, KIND_BACK: begin
          if (!full && !((kind_r == KIND_AT) && bad_ins)) begin
            ctrl.op = CELL_INSERT;
            if (kind_r == KIND_BACK) begin
              target = IW'(count);
            end else if (kind_r == KIND_AT) begin
              target = IW'(pos_x - PW'(1));
            end
          end
        end
        KIND_REMOVE: begin
          if (!empty) begin
            ctrl.op = CELL_COMPACT;
            target  = IW'(cnt_x - PW'(1) - step_x + kept_x);
            finish  = last_rem;
          end
        end
        KIND_SORT: begin
          ctrl.op = CELL_SORT;
          finish  = last_scan;
        end
        KIND_SEARCH, KIND_MAXMIN: begin
          if (!empty) begin
            ctrl.op = CELL_ROTATE;
            finish  = last_scan;
          end
        end
        KIND_READ: begin
          if (!empty && !bad_read) begin
            ctrl.op = CELL_ROTATE;
            finish  = last_scan;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bal_cell #(
      .IW   (IW),
      .CW   (CW),
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .target   (target),
      .count    (count),
      .left_key (keys[(i + CAPACITY - 1) % CAPACITY]),
      .right_key(keys[(i + 1) % CAPACITY]),
      .head_key (head),
      .key      (keys[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r     <= req.kind;
            key_r      <= req.key_value;
            pos_r      <= req.position;
            step       <= '0;
            kept       <= '0;
            found      <= 1'b0;
            res_status <= ST_OK;
            res_key    <= '0;
            res_min    <= '0;
            res_pos    <= '0;
            state      <= S_RUN;
          end
        end
        S_RUN: begin
          step <= step + CW'(1);
          case (kind_r)
            KIND_FRONT, KIND_AT, KIND_BACK: begin
              if (full) begin
                res_status <= ST_FULL;
              end else if ((kind_r == KIND_AT) && bad_ins) begin
                res_status <= ST_BADPOS;
              end else begin
                count <= count + CW'(1);
              end
            end
            KIND_REMOVE: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                kept <= kept_new;
                if (last_rem) begin
                  count   <= kept_new;
                  res_pos <= 4'(cnt_x - PW'(kept_new));
                  if (kept_new == count) begin
                    res_status <= ST_NOTFOUND;
                  end
                end
              end
            end
            KIND_SEARCH: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                if (hit && !found) begin
                  found   <= 1'b1;
                  res_pos <= 4'(step_x + PW'(1));
                end
                if (last_scan && !found && !hit) begin
                  res_status <= ST_NOTFOUND;
                end
              end
            end
            KIND_MAXMIN: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else if (in_list) begin
                if (step == '0) begin
                  res_key <= head;
                  res_min <= head;
                end else begin
                  if (res_key < head) begin
                    res_key <= head;
                  end
                  if (head < res_min) begin
                    res_min <= head;
                  end
                end
              end
            end
            KIND_READ: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else if (bad_read) begin
                res_status <= ST_BADPOS;
              end else if (step_x == pos_x - PW'(1)) begin
                res_key <= head;
              end
            end
            KIND_CLEAR: begin
              count <= '0;
            end
            default: begin
            end
          endcase
          if (finish) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_key    <= res_key;
            out_min    <= res_min;
            out_pos    <= res_pos;
            out_len    <= len_x[3:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.key_out      = out_key;
  assign rsp.min_out      = out_min;
  assign rsp.position_out = out_pos;
  assign rsp.length       = out_len;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |-> ($past(state) == S_RUN))
    else $error("length changed outside request work");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == CELL_INSERT) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == S_FIN))
    else $error("result beat raised outside finish");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_RUN))
    else $error("accepted request did not start work");

endmodule

@@ tb/bounded_array_list_engine_top_tb.sv @@
// Self-checking testbench for bounded_array_list_engine_top: directed and random request
// beats, each result checked against an in-bench list model. Depends on bal_pkg,
// bal_req_if, bal_rsp_if and the engine RTL.
module bounded_array_list_engine_top_tb;
  import bal_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY = 8;
  localparam int RANDOM_ITEMS = 1950;
  localparam int TAIL_ITEMS = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

  typedef struct {
    logic        [3:0]  kind;
    logic signed [31:0] key;
    logic        [3:0]  pos;
  } list_req_t;

  typedef struct {
    status_t            status;
    logic signed [31:0] key_out;
    logic signed [31:0] min_out;
    logic        [3:0]  position_out;
    logic        [3:0]  length;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bal_req_if req_ch();
  bal_rsp_if rsp_ch();

  bounded_array_list_engine_top #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  logic signed [31:0] list_keys [CAPACITY];
  int                 list_len = 0;
  list_req_t          queued_requests [$];
  list_rsp_t          owed_results [$];
  int                 error_count = 0;
  int                 requests_sent = 0;
  int                 results_checked = 0;
  int                 status_seen [5] = '{default: 0};
  int                 send_gap = 0;
  int                 send_pace = 0;
  int                 stall_left = 0;
  int                 drain_pace = 0;
  int                 quiet_cycles = 0;

  function automatic list_rsp_t apply_list_op(list_req_t r);
    list_rsp_t          res;
    int                 slot;
    int                 kept;
    int                 j;
    logic signed [31:0] hold;
    res.status = ST_OK;
    res.key_out = '0;
    res.min_out = '0;
    res.position_out = '0;
    case (r.kind)
      KIND_FRONT, KIND_AT, KIND_BACK: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (r.kind == KIND_AT && (r.pos < 1 || r.pos > list_len + 1)) begin
          res.status = ST_BADPOS;
        end else begin
          slot = (r.kind == KIND_FRONT) ? 0 : (r.kind == KIND_BACK) ? list_len : r.pos - 1;
          for (int i = list_len; i > slot; i--) list_keys[i] = list_keys[i - 1];
          list_keys[slot] = r.key;
          list_len++;
        end
      end
      KIND_REMOVE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          kept = 0;
          for (int i = 0; i < list_len; i++) begin
            if (list_keys[i] != r.key) begin
              list_keys[kept] = list_keys[i];
              kept++;
            end
          end
          res.position_out = 4'(list_len - kept);
          if (kept == list_len) res.status = ST_NOTFOUND;
          list_len = kept;
        end
      end
      KIND_SORT: begin
        for (int i = 1; i < list_len; i++) begin
          hold = list_keys[i];
          j = i;
          while (j > 0 && hold < list_keys[j - 1]) begin
            list_keys[j] = list_keys[j - 1];
            j--;
          end
          list_keys[j] = hold;
        end
      end
      KIND_SEARCH: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (int i = list_len - 1; i >= 0; i--) begin
            if (list_keys[i] == r.key) begin
              res.status = ST_OK;
              res.position_out = 4'(i + 1);
            end
          end
        end
      end
      KIND_MAXMIN: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.key_out = list_keys[0];
          res.min_out = list_keys[0];
          for (int i = 1; i < list_len; i++) begin
            if (list_keys[i] > res.key_out) res.key_out = list_keys[i];
            if (list_keys[i] < res.min_out) res.min_out = list_keys[i];
          end
        end
      end
      KIND_CLEAR: begin
        list_len = 0;
      end
      KIND_READ: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (r.pos < 1 || r.pos > list_len) res.status = ST_BADPOS;
        else res.key_out = list_keys[r.pos - 1];
      end
      default: begin
      end
    endcase
    res.length = 4'(list_len);
    return res;
  endfunction

  task automatic queue_request(input logic [3:0] kind, input logic signed [31:0] key,
                               input logic [3:0] pos);
    list_req_t r;
    r.kind = kind;
    r.key = key;
    r.pos = pos;
    queued_requests.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             results_checked);
    error_count++;
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    case ($urandom_range(0, 9))
      0: return KEY_MIN;
      1: return KEY_MAX;
      default: return 32'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      list_req_t nxt;
      if (req_ch.valid) begin
        nxt.kind = req_ch.kind;
        nxt.key = req_ch.key_value;
        nxt.pos = req_ch.position;
        owed_results.push_back(apply_list_op(nxt));
        requests_sent++;
      end
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (queued_requests.size() > TAIL_ITEMS && $urandom_range(0, 9) < send_pace) begin
        send_gap = $urandom_range(0, 16);
        req_ch.valid <= 1'b0;
      end else if (queued_requests.size() > 0) begin
        nxt = queued_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.kind <= nxt.kind;
        req_ch.key_value <= nxt.key;
        req_ch.position <= nxt.pos;
        if ($urandom_range(0, 49) == 0) send_pace = $urandom_range(0, 4);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          flag_mismatch("result beat with nothing owed", rsp_ch.status, 0);
        end else begin
          list_rsp_t want;
          want = owed_results.pop_front();
          if (rsp_ch.status !== want.status)
            flag_mismatch("status", rsp_ch.status, want.status);
          if (rsp_ch.key_out !== want.key_out)
            flag_mismatch("key_out", rsp_ch.key_out, want.key_out);
          if (rsp_ch.min_out !== want.min_out)
            flag_mismatch("min_out", rsp_ch.min_out, want.min_out);
          if (rsp_ch.position_out !== want.position_out)
            flag_mismatch("position_out", rsp_ch.position_out, want.position_out);
          if (rsp_ch.length !== want.length)
            flag_mismatch("length", rsp_ch.length, want.length);
          if (want.status <= ST_NOTFOUND) status_seen[want.status]++;
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (queued_requests.size() > TAIL_ITEMS && $urandom_range(0, 9) < drain_pace) begin
        stall_left = $urandom_range(0, 16);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) drain_pace = $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [3:0] kind;

    // empty list, then build up to full with both extremes
    queue_request(KIND_READ, 0, 1);
    queue_request(KIND_REMOVE, 0, 0);
    queue_request(KIND_SEARCH, 0, 0);
    queue_request(KIND_MAXMIN, 0, 0);
    queue_request(KIND_SORT, 0, 0);
    queue_request(KIND_CLEAR, 0, 0);
    queue_request(KIND_AT, 1, 0);
    queue_request(KIND_AT, 1, 2);
    queue_request(KIND_AT, KEY_MAX, 1);
    queue_request(KIND_MAXMIN, 0, 0);
    queue_request(KIND_FRONT, KEY_MIN, 0);
    queue_request(KIND_BACK, -1, 0);
    queue_request(KIND_AT, 0, 4);
    queue_request(KIND_AT, -1, 2);
    queue_request(KIND_BACK, 5, 15);
    queue_request(KIND_FRONT, 5, 0);
    queue_request(KIND_BACK, -1, 0);
    queue_request(KIND_FRONT, 7, 0);
    queue_request(KIND_AT, 7, 15);
    queue_request(KIND_READ, 0, 0);
    queue_request(KIND_READ, 0, 9);
    queue_request(KIND_READ, 0, 15);
    queue_request(KIND_READ, 0, 8);
    queue_request(KIND_SEARCH, -1, 0);
    queue_request(KIND_SEARCH, 12345, 0);
    queue_request(KIND_SORT, 0, 0);
    queue_request(KIND_MAXMIN, 0, 0);
    queue_request(KIND_REMOVE, -1, 0);
    queue_request(KIND_REMOVE, 99, 0);
    queue_request(KIND_UNUSED_LO, KEY_MAX, 15);
    queue_request(KIND_UNUSED_HI, KEY_MIN, 15);
    queue_request(KIND_CLEAR, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:17]:  kind = KIND_FRONT;
        [18:35]: kind = KIND_AT;
        [36:47]: kind = KIND_BACK;
        [48:57]: kind = KIND_REMOVE;
        [58:62]: kind = KIND_SORT;
        [63:72]: kind = KIND_SEARCH;
        [73:79]: kind = KIND_MAXMIN;
        [80:82]: kind = KIND_CLEAR;
        [83:96]: kind = KIND_READ;
        default: kind = 4'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      endcase
      queue_request(kind, pick_key(),
                    4'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 9)));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (rst || queued_requests.size() > 0 || req_ch.valid) @(posedge clk);
    while (owed_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests, %0d results checked: ok %0d, full %0d, bad position %0d,",
             requests_sent, results_checked, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_BADPOS]);
    $display("empty %0d, not found %0d; %0d mismatches", status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
